@@ design/array_list_engine_assert.svh @@
// assertion macros for the array list engine
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ALE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("array list engine: assertion failed");
`define ALE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("array list engine: assertion failed");
`else
`define ALE_ASSERT_SAME(label, ante, cons)
`define ALE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/ale_pkg.sv @@
`default_nettype none
package ale_pkg;

	localparam int ALE_DEPTH  = 128;
	localparam int WORD_W     = 32;
	localparam int OP_W       = 3;
	localparam int POS_W      = 7;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_SEARCH = 3'd3,
		OP_UPDATE = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_PUT,
		S_RESULT
	} state_t;

	typedef struct packed {
		status_t                   status;
		logic                      found;
		logic [POS_W-1:0]          match_position;
		logic signed [WORD_W-1:0]  read_value;
		logic [7:0]                live_count;
	} ale_result_t;

endpackage
`default_nettype wire

@@ design/ale_mem.sv @@
`default_nettype none
module ale_mem import ale_pkg::*; #(
	parameter int DEPTH = ALE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(DEPTH)-1:0]       waddr,
	input  wire logic signed [WORD_W-1:0]       wdata,
	input  wire logic                           re,
	input  wire logic [$clog2(DEPTH)-1:0]       raddr,
	output logic signed [WORD_W-1:0]            rdata
);

	logic signed [WORD_W-1:0] store_q [DEPTH];
	logic signed [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ design/ale_ctrl.sv @@
`default_nettype none
module ale_ctrl import ale_pkg::*; #(
	parameter int DEPTH = ALE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire logic [OP_W-1:0]                req_op,
	input  wire logic [POS_W-1:0]               req_pos,
	input  wire logic signed [WORD_W-1:0]       req_val,
	output logic                                mem_we,
	output logic [$clog2(DEPTH)-1:0]            mem_waddr,
	output logic signed [WORD_W-1:0]            mem_wdata,
	output logic                                mem_re,
	output logic [$clog2(DEPTH)-1:0]            mem_raddr,
	input  wire logic signed [WORD_W-1:0]       mem_rdata,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output ale_result_t                         res
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int LW   = (CW > 8) ? CW : 8;

	state_t                   state_q, state_d;
	logic [CW-1:0]            count_q;
	logic [OP_W-1:0]          op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [WORD_W-1:0] val_q;
	logic [AW-1:0]            ptr_q, end_q;
	logic                     issue_q;
	logic                     rd_live_s1;
	logic [AW-1:0]            rd_idx_s1;
	logic                     found_q;
	logic [AW-1:0]            match_q;
	logic signed [WORD_W-1:0] rdval_q;
	status_t                  status_q, status_d;

	logic [CMPW-1:0] pos_ext, cnt_ext, match_ext;
	logic [LW-1:0]   cnt_lw;
	logic [AW-1:0]   pos_a, cnt_a, cnt_m1_a, pos_p1_a, idx_up, idx_dn;
	logic            full, pos_over, pos_over_ins, rd_hit;

	assign pos_ext      = CMPW'(pos_q);
	assign cnt_ext      = CMPW'(count_q);
	assign pos_a        = pos_ext[AW-1:0];
	assign cnt_a        = count_q[AW-1:0];
	assign cnt_m1_a     = AW'(count_q - CW'(1));
	assign pos_p1_a     = pos_a + AW'(1);
	assign idx_up       = rd_idx_s1 + AW'(1);
	assign idx_dn       = rd_idx_s1 - AW'(1);
	assign full         = (count_q == CW'(DEPTH));
	assign pos_over     = (pos_ext >= cnt_ext);
	assign pos_over_ins = (pos_ext > cnt_ext);
	// first live word equal to the key; later reads in flight are ignored
	assign rd_hit       = rd_live_s1 && !found_q && (op_q == OP_SEARCH) && (mem_rdata == val_q);

	always_comb begin
		case (op_q)
			OP_APPEND: status_d = full ? ST_FULL : ST_DONE;
			OP_INSERT: status_d = pos_over_ins ? ST_RANGE : (full ? ST_FULL : ST_DONE);
			OP_DELETE, OP_UPDATE, OP_READ: status_d = pos_over ? ST_RANGE : ST_DONE;
			default: status_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_a;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_RESULT;
				case (op_q)
					OP_APPEND: begin
						if (!full) begin
							mem_we    = 1'b1;
							mem_waddr = cnt_a;
						end
					end
					OP_INSERT: begin
						if (!pos_over_ins && !full) begin
							if (pos_ext == cnt_ext) begin
								mem_we    = 1'b1;
								mem_waddr = cnt_a;
							end else begin
								state_d = S_SCAN;
							end
						end
					end
					OP_DELETE: begin
						if (!pos_over && ((pos_ext + CMPW'(1)) < cnt_ext)) begin
							state_d = S_SCAN;
						end
					end
					OP_SEARCH: begin
						if (count_q != '0) begin
							state_d = S_SCAN;
						end
					end
					OP_UPDATE: begin
						if (!pos_over) begin
							mem_we = 1'b1;
						end
					end
					OP_READ: begin
						if (!pos_over) begin
							state_d = S_SCAN;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				// read at ptr; on insert or delete, write back the word read last cycle one slot over
				mem_re = issue_q;
				if (rd_live_s1 && (op_q == OP_INSERT)) begin
					mem_we    = 1'b1;
					mem_waddr = idx_up;
					mem_wdata = mem_rdata;
				end else if (rd_live_s1 && (op_q == OP_DELETE)) begin
					mem_we    = 1'b1;
					mem_waddr = idx_dn;
					mem_wdata = mem_rdata;
				end
				if (!issue_q && !rd_live_s1) begin
					state_d = (op_q == OP_INSERT) ? S_PUT : S_RESULT;
				end
			end
			S_PUT: begin
				mem_we  = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			issue_q    <= 1'b0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_live_s1 <= (state_q == S_SCAN) && issue_q;
			case (state_q)
				S_DECIDE: begin
					issue_q <= (state_d == S_SCAN);
					if (status_d == ST_DONE) begin
						if ((op_q == OP_APPEND) || ((op_q == OP_INSERT) && (pos_ext == cnt_ext))) begin
							count_q <= count_q + CW'(1);
						end
						// delete of the last live word moves nothing
						if ((op_q == OP_DELETE) && (state_d == S_RESULT)) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_SCAN: begin
					if (issue_q && ((ptr_q == end_q) || rd_hit)) begin
						issue_q <= 1'b0;
					end
					if (!issue_q && !rd_live_s1 && (op_q == OP_DELETE)) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			op_q  <= req_op;
			pos_q <= req_pos;
			val_q <= req_val;
		end
		case (state_q)
			S_DECIDE: begin
				status_q <= status_d;
				found_q  <= 1'b0;
				match_q  <= '0;
				rdval_q  <= '0;
				case (op_q)
					OP_INSERT: begin
						ptr_q <= cnt_m1_a;
						end_q <= pos_a;
					end
					OP_DELETE: begin
						ptr_q <= pos_p1_a;
						end_q <= cnt_m1_a;
					end
					OP_SEARCH: begin
						ptr_q <= '0;
						end_q <= cnt_m1_a;
					end
					default: begin
						ptr_q <= pos_a;
						end_q <= pos_a;
					end
				endcase
			end
			S_SCAN: begin
				if (issue_q && (ptr_q != end_q)) begin
					ptr_q <= (op_q == OP_INSERT) ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
				end
				rd_idx_s1 <= ptr_q;
				if (rd_hit) begin
					found_q <= 1'b1;
					match_q <= rd_idx_s1;
				end
				if (rd_live_s1 && (op_q == OP_READ)) begin
					rdval_q <= mem_rdata;
				end
			end
			default: ;
		endcase
	end

	assign match_ext = CMPW'(match_q);
	assign cnt_lw    = LW'(count_q);

	always_comb begin
		res.status         = status_q;
		res.found          = found_q;
		res.match_position = match_ext[POS_W-1:0];
		res.read_value     = rdval_q;
		res.live_count     = cnt_lw[7:0];
	end

endmodule
`default_nettype wire

@@ design/array_list_engine.sv @@
// one request at a time; a new request is taken once the previous result leaves the controller
// append, update, reject, unused op: decide state, result state, then the output register
// read, delete, search, insert: a scan state may come between decide and result, insert then
// adds a put state; search stops at the first match; the word memory has a single read and a single write port
// reset clears the word count and all handshake state; stored words stay undefined, no clear pass
`default_nettype none
`include "array_list_engine_assert.svh"
module array_list_engine import ale_pkg::*; #(
	parameter int DEPTH = ALE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_DATA_W-1:0]   s_tdata,   // position[6:0], value[38:7], zero pad
	input  wire logic [OP_W-1:0]        s_tuser,   // op[2:0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_DATA_W-1:0]       m_tdata    // status[1:0], found[2], match_position[9:3],
	                                               // read_value[41:10], live_count[49:42], zero pad
);

	localparam int AW = $clog2(DEPTH);

	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic signed [WORD_W-1:0] mem_wdata, mem_rdata;
	logic                     res_valid, res_ready;
	ale_result_t              res;
	logic                     m_tvalid_q;
	ale_result_t              out_q;

	ale_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (s_tuser),
		.req_pos   (s_tdata[POS_W-1:0]),
		.req_val   (s_tdata[POS_W+WORD_W-1:POS_W]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	ale_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register frees the controller while a result waits for its transfer
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_q.live_count, out_q.read_value, out_q.match_position,
		out_q.found, out_q.status};

	`ALE_ASSERT_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready)
	`ALE_ASSERT_SAME(a_idle_has_no_result, s_tready, !res_valid)
	`ALE_ASSERT_SAME(a_found_is_done, m_tvalid_q && out_q.found, out_q.status == ST_DONE)
	`ALE_ASSERT_SAME(a_reject_is_clean, m_tvalid_q && (out_q.status != ST_DONE),
		!out_q.found && (out_q.read_value == '0))

endmodule
`default_nettype wire
